### hw/rtl/slcd_pkg.sv
`timescale 1ns / 1ps

package slcd_pkg;

	// Sync pattern
	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	// Length mode after reset
	localparam logic LENGTH_PRESENT_RST = 1'b1;

	// One result item
	typedef struct packed {
		logic       item_kind;
		logic [7:0] packet_type;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic       last;
		logic       checksum_ok;
	} res_t;

endpackage

### hw/rtl/sync_length_checksum_deframer_unit.sv
`timescale 1ns / 1ps
// A byte accepted into the input register passes through the FSM into the output
// register, where any result it causes is offered; a stall can hold it in between.
// Throughput: one byte per cycle while the output side does not stall.
// Input register and output register each hold one item; stall is set only when
// the output register is full and stalled.
// Reset (arst_n low, asynchronous): both registers empty, hunting the first
// sync byte, length mode on.

module sync_length_checksum_deframer_unit
	import slcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       item_kind,
	output logic [7:0] packet_type,
	output logic [7:0] data_byte,
	output logic [7:0] byte_index,
	output logic       last,
	output logic       checksum_ok
);

	logic       length_present_q;
	logic       vld_s1;
	logic [7:0] rx_byte_s1;
	logic       out_free;
	logic       fire;
	logic       res_valid;
	res_t       res;
	res_t       res_out;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_present_q <= LENGTH_PRESENT_RST;
		end else if (cfg_write) begin
			length_present_q <= cfg_data;
		end
	end

	// Input register: advances whenever the output register has room
	assign fire     = vld_s1 && out_free;
	assign in_stall = vld_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	slcd_fsm u_fsm (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.rx_byte        (rx_byte_s1),
		.length_present (length_present_q),
		.res            (res),
		.res_valid      (res_valid)
	);

	slcd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res_in    (res),
		.out_stall (out_stall),
		.free      (out_free),
		.out_valid (out_valid),
		.res_out   (res_out)
	);

	assign item_kind   = res_out.item_kind;
	assign packet_type = res_out.packet_type;
	assign data_byte   = res_out.data_byte;
	assign byte_index  = res_out.byte_index;
	assign last        = res_out.last;
	assign checksum_ok = res_out.checksum_ok;

endmodule

### hw/rtl/slcd_fsm.sv
`timescale 1ns / 1ps

module slcd_fsm
	import slcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] rx_byte,
	input  logic       length_present,
	output res_t       res,
	output logic       res_valid
);

	localparam logic [2:0] PH_HUNT1 = 3'd0;
	localparam logic [2:0] PH_HUNT2 = 3'd1;
	localparam logic [2:0] PH_TYPE  = 3'd2;
	localparam logic [2:0] PH_COUNT = 3'd3;
	localparam logic [2:0] PH_BODY  = 3'd4;

	logic [2:0] phase_q, phase_d;
	logic [7:0] type_q, type_d;
	logic [7:0] left_q, left_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] pos_q, pos_d;

	// Next state and result for the byte in the input register
	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		left_d    = left_q;
		sum_d     = sum_q;
		pos_d     = pos_q;
		res_valid = 1'b0;
		res       = '{item_kind: KIND_END, packet_type: type_q, data_byte: 8'd0,
			byte_index: 8'd0, last: 1'b1, checksum_ok: 1'b1};
		case (phase_q)
			PH_HUNT2: begin
				phase_d = (rx_byte == SYNC_SECOND) ? PH_TYPE : PH_HUNT1;
			end
			PH_TYPE: begin
				type_d          = rx_byte;
				res.packet_type = rx_byte;
				if (length_present) begin
					phase_d = PH_COUNT;
				end else begin
					// no count byte: packet closes right here
					phase_d   = PH_HUNT1;
					res_valid = 1'b1;
				end
			end
			PH_COUNT: begin
				sum_d  = 8'd0;
				pos_d  = 8'd0;
				left_d = rx_byte;
				if (rx_byte == 8'd0) begin
					phase_d   = PH_HUNT1;
					res_valid = 1'b1;
				end else begin
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				sum_d          = sum_q + rx_byte;
				left_d         = left_q - 8'd1;
				res_valid      = 1'b1;
				res.data_byte  = rx_byte;
				res.byte_index = pos_q;
				if (left_q == 8'd1) begin
					// checksum byte closes the packet
					phase_d         = PH_HUNT1;
					res.checksum_ok = (sum_d == 8'd0);
				end else begin
					res.item_kind   = KIND_PAYLOAD;
					res.last        = 1'b0;
					res.checksum_ok = 1'b0;
					pos_d           = pos_q + 8'd1;
				end
			end
			default: begin
				phase_d = (rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
			end
		endcase
	end

	// State update on each transfer out of the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			type_q  <= 8'd0;
			left_q  <= 8'd0;
			sum_q   <= 8'd0;
			pos_q   <= 8'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			pos_q   <= pos_d;
		end
	end

endmodule

### hw/rtl/slcd_out_reg.sv
`timescale 1ns / 1ps

module slcd_out_reg
	import slcd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic out_stall,
	output logic free,
	output logic out_valid,
	output res_t res_out
);

	logic vld_s2;
	res_t res_s2;

	// Register can take a new result when empty or being drained
	assign free      = !vld_s2 || !out_stall;
	assign out_valid = vld_s2;
	assign res_out   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (free) begin
			vld_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_s2 <= res_in;
		end
	end

endmodule

### hw/rtl/slcd_checker.sv
`timescale 1ns / 1ps

module slcd_checker
	import slcd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       item_kind,
	input logic [7:0] byte_index,
	input logic       last,
	input logic       checksum_ok
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// Payload items carry no end flags
	a_payload_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_PAYLOAD |-> !last && !checksum_ok)
		else $error("payload item with end flags");

	// End items always close the packet
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_END |-> last)
		else $error("end item without last");

	// Back-to-back payload transfers count up by one
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && item_kind == KIND_PAYLOAD |=>
		(!out_valid || item_kind == KIND_END || byte_index == $past(byte_index) + 8'd1))
		else $error("payload index out of sequence");

endmodule

bind sync_length_checksum_deframer_unit slcd_checker u_slcd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.item_kind   (item_kind),
	.byte_index  (byte_index),
	.last        (last),
	.checksum_ok (checksum_ok)
);

### test/sync_length_checksum_deframer_unit_tb.sv
`timescale 1ns / 1ps

module sync_length_checksum_deframer_unit_tb;
	import slcd_pkg::*;

	localparam int TOTAL_BYTES     = 1300;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int IDLE_SETTLE     = 4;
	localparam int END_SETTLE      = 10;

	// Deframer phase as tracked by the predictor
	typedef enum logic [2:0] {
		HUNT_AA,
		HUNT_55,
		TAKE_TYPE,
		TAKE_COUNT,
		TAKE_BODY
	} hunt_phase_e;

	// One row of the directed stimulus
	typedef struct {
		bit         is_cfg;
		logic [7:0] value;
		bit         typed;
		res_t       want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write = 1'b0;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic       item_kind;
	logic [7:0] packet_type;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic       last;
	logic       checksum_ok;

	// Predictor state
	logic        length_mode = LENGTH_PRESENT_RST;
	hunt_phase_e track_phase = HUNT_AA;
	logic [7:0]  track_type = 8'h00;
	logic [7:0]  track_left = 8'h00;
	logic [7:0]  track_sum = 8'h00;
	logic [7:0]  track_pos = 8'h00;

	res_t      expected_items[$];
	stim_row_t stim_rows[$];
	res_t      oldest;
	int        mismatches = 0;
	int        bytes_sent = 0;
	bit        steady_sender = 1'b0;
	bit        hold_off_req = 1'b0;

	sync_length_checksum_deframer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.item_kind(item_kind),
		.packet_type(packet_type),
		.data_byte(data_byte),
		.byte_index(byte_index),
		.last(last),
		.checksum_ok(checksum_ok)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the deframer by one received byte; returns the result it causes, if any
	function automatic void deframe_byte(input logic [7:0] b, output bit produced,
			output res_t r);
		produced = 1'b0;
		r = '0;
		case (track_phase)
			HUNT_55: begin
				track_phase = (b == SYNC_SECOND) ? TAKE_TYPE : HUNT_AA;
			end
			TAKE_TYPE: begin
				track_type = b;
				if (!length_mode) begin
					track_phase = HUNT_AA;
					produced = 1'b1;
					r = res_t'{KIND_END, b, 8'h00, 8'h00, 1'b1, 1'b1};
				end else begin
					track_phase = TAKE_COUNT;
				end
			end
			TAKE_COUNT: begin
				track_sum = 8'h00;
				track_pos = 8'h00;
				if (b == 8'h00) begin
					track_left = 8'h00;
					track_phase = HUNT_AA;
					produced = 1'b1;
					r = res_t'{KIND_END, track_type, 8'h00, 8'h00, 1'b1, 1'b1};
				end else begin
					track_left = b;
					track_phase = TAKE_BODY;
				end
			end
			TAKE_BODY: begin
				track_sum = track_sum + b;
				track_left = track_left - 8'd1;
				produced = 1'b1;
				if (track_left == 8'h00) begin
					track_phase = HUNT_AA;
					r = res_t'{KIND_END, track_type, b, track_pos, 1'b1,
						track_sum == 8'h00};
				end else begin
					r = res_t'{KIND_PAYLOAD, track_type, b, track_pos, 1'b0, 1'b0};
					track_pos = track_pos + 8'd1;
				end
			end
			default: begin
				track_phase = (b == SYNC_FIRST) ? HUNT_55 : HUNT_AA;
			end
		endcase
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Count byte: mostly short packets, the extremes now and then
	function automatic int pick_count(input bit full);
		int r;
		if (full)
			return 255;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 0;
		else if (r < 12)
			return 1;
		else if (r < 13)
			return 255;
		else if (r < 14)
			return 254;
		return $urandom_range(2, 12);
	endfunction

	function automatic void add_row(input bit is_cfg, input logic [7:0] value,
			input bit typed = 1'b0, input res_t want = '0);
		stim_row_t row;
		row.is_cfg = is_cfg;
		row.value = value;
		row.typed = typed;
		row.want = want;
		stim_rows.push_back(row);
	endfunction

	// Offer one byte, hold it until the transfer, then record what it should cause
	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
			input res_t want = '0);
		int gap;
		bit produced;
		res_t r;
		gap = steady_sender ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		deframe_byte(b, produced, r);
		if (typed) begin
			r = want;
			produced = 1'b1;
		end
		if (produced)
			expected_items.push_back(r);
		bytes_sent++;
	endtask

	// Stop offering and let every pending result drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_items.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_length_mode(input logic mode);
		cfg_write <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		length_mode = mode;
		cfg_write <= 1'b0;
	endtask

	// One random unit: a well-formed packet, line noise, or a broken frame
	task automatic send_unit(input bit full = 1'b0);
		int pick;
		int count;
		logic [7:0] sum;
		logic [7:0] b;
		pick = full ? 0 : $urandom_range(0, 99);
		if (pick < 80) begin
			send_byte(SYNC_FIRST);
			send_byte(SYNC_SECOND);
			send_byte(8'($urandom_range(0, 255)));
			if (length_mode) begin
				count = pick_count(full);
				send_byte(8'(count));
				sum = 8'h00;
				for (int k = 1; k < count; k++) begin
					b = 8'($urandom_range(0, 255));
					sum = sum + b;
					send_byte(b);
				end
				// closing byte: usually a good checksum
				if (count > 0) begin
					b = ($urandom_range(0, 9) < 7) ? 8'(-sum) : 8'($urandom_range(0, 255));
					send_byte(b);
				end
			end
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 6))
				send_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST :
					8'($urandom_range(0, 255)));
		end else begin
			send_byte(SYNC_FIRST);
			if ($urandom_range(0, 1)) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				// truncated frame: in length mode its body swallows whatever follows
				send_byte(SYNC_SECOND);
				send_byte(8'($urandom_range(0, 255)));
				if (length_mode) begin
					send_byte(8'($urandom_range(4, 20)));
					repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	// Check one field of a result transfer
	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Result side: compare each transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_items.size() == 0) begin
				$error("result with nothing expected: kind %0b type %0h data %0h",
					item_kind, packet_type, data_byte);
				mismatches++;
			end else begin
				oldest = expected_items.pop_front();
				check_field("item_kind", 8'(oldest.item_kind), 8'(item_kind));
				check_field("packet_type", oldest.packet_type, packet_type);
				check_field("data_byte", oldest.data_byte, data_byte);
				check_field("byte_index", oldest.byte_index, byte_index);
				check_field("last", 8'(oldest.last), 8'(last));
				check_field("checksum_ok", 8'(oldest.checksum_ok), 8'(checksum_ok));
			end
		end
	end

	// Receiver stalls: free stretches, short and long stalls, one long hold-off on request
	initial begin
		int free_len;
		int stall_len;
		out_stall <= 1'b0;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				free_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) :
					$urandom_range(1, 6);
				stall_len = pick_gap();
				out_stall <= 1'b0;
				repeat (free_len) @(posedge clk);
				if (stall_len > 0) begin
					out_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
			end
		end
	end

	// Stimulus
	initial begin
		int phase_no;
		int units;
		logic mode;

		// noise, then a broken sync pair whose second byte is not taken as a new start
		add_row(1'b0, 8'h00);
		add_row(1'b0, SYNC_FIRST);
		add_row(1'b0, 8'h00);
		add_row(1'b0, SYNC_SECOND);
		// count of zero
		add_row(1'b0, SYNC_FIRST);
		add_row(1'b0, SYNC_SECOND);
		add_row(1'b0, 8'hFF);
		add_row(1'b0, 8'h00, 1'b1, res_t'{KIND_END, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1});
		// count of one, checksum byte zero
		add_row(1'b0, SYNC_FIRST);
		add_row(1'b0, SYNC_SECOND);
		add_row(1'b0, 8'h00);
		add_row(1'b0, 8'h01);
		add_row(1'b0, 8'h00, 1'b1, res_t'{KIND_END, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1});
		// two payload bytes and a good checksum
		add_row(1'b0, SYNC_FIRST);
		add_row(1'b0, SYNC_SECOND);
		add_row(1'b0, 8'h3C);
		add_row(1'b0, 8'h03);
		add_row(1'b0, 8'hFF, 1'b1, res_t'{KIND_PAYLOAD, 8'h3C, 8'hFF, 8'h00, 1'b0, 1'b0});
		add_row(1'b0, 8'h80, 1'b1, res_t'{KIND_PAYLOAD, 8'h3C, 8'h80, 8'h01, 1'b0, 1'b0});
		add_row(1'b0, 8'h81, 1'b1, res_t'{KIND_END, 8'h3C, 8'h81, 8'h02, 1'b1, 1'b1});
		// bad checksum
		add_row(1'b0, SYNC_FIRST);
		add_row(1'b0, SYNC_SECOND);
		add_row(1'b0, 8'hA5);
		add_row(1'b0, 8'h01);
		add_row(1'b0, 8'h01, 1'b1, res_t'{KIND_END, 8'hA5, 8'h01, 8'h00, 1'b1, 1'b0});
		// length mode off: the type byte closes the packet
		add_row(1'b1, 8'h00);
		add_row(1'b0, SYNC_FIRST);
		add_row(1'b0, SYNC_SECOND);
		add_row(1'b0, 8'h77, 1'b1, res_t'{KIND_END, 8'h77, 8'h00, 8'h00, 1'b1, 1'b1});
		add_row(1'b1, 8'h01);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_cfg) begin
				wait_idle();
				write_length_mode(stim_rows[i].value[0]);
			end else begin
				send_byte(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].want);
			end
		end

		// Random phases, each under its own length mode and pacing
		phase_no = 0;
		while (bytes_sent < TOTAL_BYTES) begin
			wait_idle();
			mode = ($urandom_range(0, 3) != 0);
			if (phase_no == 1)
				mode = 1'b0;
			if (phase_no == 2 || phase_no == 3)
				mode = 1'b1;
			write_length_mode(mode);
			steady_sender = ($urandom_range(0, 3) == 0);
			if (phase_no == 2) begin
				steady_sender = 1'b1;
				hold_off_req = 1'b1;
				// start sending only once the receiver has begun its hold-off
				wait (!hold_off_req);
			end
			if (phase_no == 3)
				send_unit(1'b1);
			units = $urandom_range(10, 40);
			repeat (units) send_unit();
			phase_no++;
		end

		wait_idle();
		repeat (END_SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("PASS sync_length_checksum_deframer_unit");
		else
			$display("FAIL sync_length_checksum_deframer_unit");
		$finish;
	end

	// Watchdog
	initial begin
		#50_000_000;
		$display("FAIL sync_length_checksum_deframer_unit");
		$finish;
	end

endmodule
